// ===== rtl/octmc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octmc_pkg
// Shared constants and types of the octree Morton code core.
// ----------------------------------------------------------------------------
package octmc_pkg;

    localparam int LEVELS_DEF     = 10;
    localparam int COORD_BITS_DEF = 32;

    localparam int NUM_AXES  = 3;
    localparam int EXT_W     = 31;
    localparam int CODE_W    = 30;
    localparam int CFG_IDX_W = 2;

    localparam logic [EXT_W-1:0] EXTENT_RESET = 31'd67108864;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENT_X = 2'd0,
        REG_EXTENT_Y = 2'd1,
        REG_EXTENT_Z = 2'd2
    } t_cfg_reg;

    localparam int AXIS_X = 0;
    localparam int AXIS_Y = 1;
    localparam int AXIS_Z = 2;

    // split and step of one axis, unsigned Q16.16; both stay below the extent
    typedef struct packed {
        logic [EXT_W-1:0] split;
        logic [EXT_W-1:0] step;
    } t_axis_geom;

endpackage
`default_nettype wire

// ===== rtl/octmc_level.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octmc_level
// One level of the bisection: tests z, y and x against their splits, moves
// each split by its step, halves the steps and appends three code bits.
// ----------------------------------------------------------------------------
module octmc_level #(
    parameter int COORD_BITS = octmc_pkg::COORD_BITS_DEF,
    parameter int FULL_W     = 3 * octmc_pkg::LEVELS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [COORD_BITS-1:0] i_point [octmc_pkg::NUM_AXES],
    input  octmc_pkg::t_axis_geom        i_geom  [octmc_pkg::NUM_AXES],
    input  logic [FULL_W-1:0]            i_code,
    output logic                         o_valid,
    output logic signed [COORD_BITS-1:0] o_point [octmc_pkg::NUM_AXES],
    output octmc_pkg::t_axis_geom        o_geom  [octmc_pkg::NUM_AXES],
    output logic [FULL_W-1:0]            o_code
);
    import octmc_pkg::*;

    localparam int CMP_W = ((COORD_BITS > EXT_W) ? COORD_BITS : EXT_W) + 1;

    logic                         r_valid;
    logic signed [COORD_BITS-1:0] r_point [NUM_AXES];
    t_axis_geom                   r_geom  [NUM_AXES];
    logic [FULL_W-1:0]            r_code;

    t_axis_geom          n_geom [NUM_AXES];
    logic [FULL_W-1:0]   n_code;
    logic [NUM_AXES-1:0] w_hit;

    always_comb begin
        logic signed [CMP_W-1:0] pt_ext;
        logic signed [CMP_W-1:0] split_ext;
        for (int a = 0; a < NUM_AXES; a++) begin
            pt_ext    = CMP_W'(i_point[a]);
            split_ext = $signed(CMP_W'(i_geom[a].split));
            w_hit[a]  = (pt_ext >= split_ext);
            // move the split toward the point's side, then halve the step
            if (w_hit[a]) begin
                n_geom[a].split = i_geom[a].split + i_geom[a].step;
            end else begin
                n_geom[a].split = i_geom[a].split - i_geom[a].step;
            end
            n_geom[a].step = i_geom[a].step >> 1;
        end
        // z lands in the highest bit of the triple, x in the lowest
        n_code = (i_code << 3) |
                 FULL_W'({w_hit[AXIS_Z], w_hit[AXIS_Y], w_hit[AXIS_X]});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_point <= i_point;
        r_geom  <= n_geom;
        r_code  <= n_code;
    end

    assign o_valid = r_valid;
    assign o_point = r_point;
    assign o_geom  = r_geom;
    assign o_code  = r_code;

endmodule
`default_nettype wire

// ===== rtl/octree_morton_code_3d_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// octree_morton_code_3d_core
// Octree cell code of a 3D point: bisects the box from the origin to the
// configured extents, one level per pipeline stage.
//
//   channel   ports                                   moves
//   --------  --------------------------------------  ----------------------
//   request   start, busy, i_point_x/y/z              one point per cycle
//   result    o_valid, o_cell_code                    one code per request
//   config    i_cfg_we, i_cfg_idx, i_cfg_wdata        extent_x/y/z writes
//
// One request enters every cycle; busy is always low. Each code passes
// through one entry stage that loads splits and steps from the extents, then
// through one stage per level of the bisection. Reset clears the valid bits
// and loads the extents with 1024.0. Results leave in request order and are
// not held back.
// ----------------------------------------------------------------------------
module octree_morton_code_3d_core #(
    parameter int LEVELS     = octmc_pkg::LEVELS_DEF,
    parameter int COORD_BITS = octmc_pkg::COORD_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        i_point_x,
    input  logic signed [COORD_BITS-1:0]        i_point_y,
    input  logic signed [COORD_BITS-1:0]        i_point_z,
    output logic                                o_valid,
    output logic [octmc_pkg::CODE_W-1:0]        o_cell_code,
    input  logic                                i_cfg_we,
    input  logic [octmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [octmc_pkg::EXT_W-1:0]         i_cfg_wdata
);
    import octmc_pkg::*;

    localparam int FULL_W = 3 * LEVELS;

    logic [EXT_W-1:0] r_extent [NUM_AXES];

    logic                         w_valid [LEVELS+1];
    logic signed [COORD_BITS-1:0] w_point [LEVELS+1][NUM_AXES];
    t_axis_geom                   w_geom  [LEVELS+1][NUM_AXES];
    logic [FULL_W-1:0]            w_code  [LEVELS+1];

    logic                         r_valid0;
    logic signed [COORD_BITS-1:0] r_point0 [NUM_AXES];
    t_axis_geom                   r_geom0  [NUM_AXES];

    assign busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_extent[a] <= EXTENT_RESET;
            end
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_EXTENT_X: r_extent[AXIS_X] <= i_cfg_wdata;
                REG_EXTENT_Y: r_extent[AXIS_Y] <= i_cfg_wdata;
                REG_EXTENT_Z: r_extent[AXIS_Z] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // entry stage: split at half the extent, step at a quarter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_point0[AXIS_X] <= i_point_x;
        r_point0[AXIS_Y] <= i_point_y;
        r_point0[AXIS_Z] <= i_point_z;
        for (int a = 0; a < NUM_AXES; a++) begin
            r_geom0[a].split <= r_extent[a] >> 1;
            r_geom0[a].step  <= r_extent[a] >> 2;
        end
    end

    assign w_valid[0] = r_valid0;
    assign w_point[0] = r_point0;
    assign w_geom[0]  = r_geom0;
    assign w_code[0]  = '0;

    for (genvar l = 0; l < LEVELS; l++) begin : g_level
        octmc_level #(
            .COORD_BITS (COORD_BITS),
            .FULL_W     (FULL_W)
        ) u_level (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[l]),
            .i_point (w_point[l]),
            .i_geom  (w_geom[l]),
            .i_code  (w_code[l]),
            .o_valid (w_valid[l+1]),
            .o_point (w_point[l+1]),
            .o_geom  (w_geom[l+1]),
            .o_code  (w_code[l+1])
        );
    end

    // drop code bits above the field, or pad with zeros when LEVELS is short
    assign o_valid     = w_valid[LEVELS];
    assign o_cell_code = CODE_W'(w_code[LEVELS]);

endmodule
`default_nettype wire
